/* design/sm4_block_and_ofb_cipher_unit_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the SM4 cipher unit
// Each macro builds a labeled concurrent assertion on clk / arst_n.
// ----------------------------------------------------------------------------
`ifndef SM4_BLOCK_AND_OFB_CIPHER_UNIT_DEFINES_SVH
`define SM4_BLOCK_AND_OFB_CIPHER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SM4_ASSERT_IMP(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define SM4_ASSERT_NXT(label, a, c) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define SM4_ASSERT_IMP(label, a, c)
`define SM4_ASSERT_NXT(label, a, c)
`endif
`endif

/* design/sm4_pkg.sv */
// ----------------------------------------------------------------------------
// SM4 package
// Shared constants, types and round functions of the SM4 cipher unit.
// ----------------------------------------------------------------------------
`default_nettype none
package sm4_pkg;
	localparam int RoundCount = 32;
	localparam int RkIdxW = 5;
	localparam int QueueDepth = 2;

	typedef enum logic [1:0] {
		OP_ENC = 2'd0,
		OP_DEC = 2'd1,
		OP_OFB = 2'd2,
		OP_BAD = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_KEY_HIGH = 2'd0,
		REG_KEY_LOW  = 2'd1,
		REG_IV_HIGH  = 2'd2,
		REG_IV_LOW   = 2'd3
	} reg_idx_t;

	// classified word passed from front to back
	typedef struct packed {
		op_t         op;
		logic        restart;
		logic [4:0]  byte_count;
		logic [63:0] data_high;
		logic [63:0] data_low;
	} cmd_t;

	localparam logic [31:0] FK [4] = '{32'hA3B1BAC6, 32'h56AA3350,
		32'h677D9197, 32'hB27022DC};

	localparam logic [7:0] SBOX [256] = '{
	8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
	8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
	8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
	8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
	8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
	8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
	8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
	8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
	8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
	8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
	8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
	8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
	8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
	8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
	8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
	8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48};

	function automatic logic [31:0] subst_word(input logic [31:0] a);
		subst_word = {SBOX[a[31:24]], SBOX[a[23:16]], SBOX[a[15:8]], SBOX[a[7:0]]};
	endfunction

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		rotl = (x << n) | (x >> (32 - n));
	endfunction

	function automatic logic [31:0] round_mix(input logic [31:0] a);
		logic [31:0] b;
		b = subst_word(a);
		round_mix = b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
	endfunction

	function automatic logic [31:0] key_mix(input logic [31:0] a);
		logic [31:0] b;
		b = subst_word(a);
		key_mix = b ^ rotl(b, 13) ^ rotl(b, 23);
	endfunction

	// chain constant: byte j of word i is (4i+j)*7 mod 256
	function automatic logic [31:0] chain_const(input logic [RkIdxW-1:0] i);
		logic [7:0] base;
		base = {i, 2'b00} * 8'd7;
		chain_const = {base, base + 8'd7, base + 8'd14, base + 8'd21};
	endfunction

	// mask keeping the first n bytes of a 64-bit big-endian word
	function automatic logic [63:0] byte_mask(input logic [3:0] n);
		logic [63:0] m;
		m = '0;
		for (int b = 0; b < 8; b++) begin
			if (n > 4'(b)) m[63 - 8*b -: 8] = 8'hff;
		end
		byte_mask = m;
	endfunction
endpackage
`default_nettype wire

/* design/sm4_ram.sv */
// ----------------------------------------------------------------------------
// SM4 generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module sm4_ram #(
	parameter int Width = 32,
	parameter int Depth = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* design/sm4_front.sv */
// ----------------------------------------------------------------------------
// SM4 front end
// Accepts input words, classifies the operation and queues them.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sm4_block_and_ofb_cipher_unit_defines.svh"
module sm4_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire sm4_pkg::cmd_t     in_cmd,
	output logic                   q_valid,
	input  wire logic              q_pop,
	output sm4_pkg::cmd_t          q_cmd
);
	import sm4_pkg::*;

	cmd_t       slot_q [QueueDepth];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;
	logic       push;
	cmd_t       cls;

	assign in_stall = (cnt_q == 2'(QueueDepth));
	assign push = in_valid && !in_stall;
	assign q_valid = (cnt_q != 2'd0);
	assign q_cmd = slot_q[rptr_q];

	// clamp byte count for OFB; ECB words carry a full block
	always_comb begin
		cls = in_cmd;
		if (in_cmd.byte_count > 5'd16) cls.byte_count = 5'd16;
		if (in_cmd.op != OP_OFB) cls.byte_count = 5'd16;
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wptr_q] <= cls;
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (q_pop) rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	`SM4_ASSERT_IMP(a_no_pop_empty, q_pop, cnt_q != 2'd0)
	`SM4_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= 2'(QueueDepth))
	`SM4_ASSERT_NXT(a_push_counts, push && !q_pop, cnt_q == $past(cnt_q) + 2'd1)
endmodule
`default_nettype wire

/* design/sm4_back.sv */
// ----------------------------------------------------------------------------
// SM4 back end
// Key expansion into the round key RAM and the shared round unit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sm4_block_and_ofb_cipher_unit_defines.svh"
module sm4_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [63:0]       cfg_data,
	input  wire logic              q_valid,
	output logic                   q_pop,
	input  wire sm4_pkg::cmd_t     q_cmd,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [63:0]            result_high,
	output logic [63:0]            result_low
);
	import sm4_pkg::*;

	typedef enum logic [2:0] {
		ST_KEXP, ST_IDLE, ST_PREP, ST_RUN, ST_DONE
	} bst_t;

	bst_t st_q, st_d;
	logic [63:0] key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
	logic [31:0] x_q [4];
	logic [127:0] fb_q;
	logic [RkIdxW:0] rnd_q;
	cmd_t cmd_q;
	logic out_valid_q;
	logic [63:0] res_hi_q, res_lo_q;

	logic rk_we;
	logic [RkIdxW-1:0] rk_waddr, rk_raddr;
	logic [31:0] rk_rdata, rk_new, mix_in;
	logic [RkIdxW-1:0] r5;
	logic [127:0] fin;
	logic [127:0] ks;
	logic [127:0] res_d;
	logic key_wr;
	logic load_out;

	assign r5 = rnd_q[RkIdxW-1:0];
	assign key_wr = cfg_we && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW);

	sm4_ram #(.Width(32), .Depth(RoundCount)) u_rk (
		.clk(clk), .we(rk_we), .waddr(rk_waddr), .wdata(rk_new),
		.raddr(rk_raddr), .rdata(rk_rdata));

	// one round of the shared unit, key or data
	always_comb begin
		mix_in = x_q[r5[1:0] + 2'd1] ^ x_q[r5[1:0] + 2'd2]
			^ x_q[r5[1:0] + 2'd3];
		if (st_q == ST_KEXP) rk_new = x_q[r5[1:0]] ^ key_mix(mix_in ^ chain_const(r5));
		else rk_new = x_q[r5[1:0]] ^ round_mix(mix_in ^ rk_rdata);
	end

	assign rk_we = (st_q == ST_KEXP);
	assign rk_waddr = r5;
	// read one round ahead so data is ready at the round
	always_comb begin
		logic [RkIdxW-1:0] nr;
		nr = (st_q == ST_RUN) ? r5 + 5'd1 : 5'd0;
		rk_raddr = (cmd_q.op == OP_DEC) ? 5'(RoundCount - 1) - nr : nr;
	end

	assign fin = {x_q[3], x_q[2], x_q[1], x_q[0]};
	assign ks = fin ^ {cmd_q.data_high, cmd_q.data_low};

	// shape the result word: keystream mask for OFB, zero for the unused code
	always_comb begin
		res_d = fin;
		if (cmd_q.op == OP_OFB) begin
			res_d = {ks[127:64] & byte_mask(cmd_q.byte_count > 5'd8 ?
					4'd8 : cmd_q.byte_count[3:0]),
				ks[63:0] & byte_mask(cmd_q.byte_count > 5'd8 ?
					4'(cmd_q.byte_count - 5'd8) : 4'd0)};
		end else if (cmd_q.op == OP_BAD) begin
			res_d = '0;
		end
	end

	assign load_out = (st_q == ST_DONE) && (!out_valid_q || !out_stall) && !key_wr;

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_KEXP: if (rnd_q == 6'(RoundCount - 1)) st_d = ST_IDLE;
			ST_IDLE: if (q_valid) st_d = ST_PREP;
			ST_PREP: st_d = ST_RUN;
			ST_RUN:  if (rnd_q == 6'(RoundCount - 1)) st_d = ST_DONE;
			ST_DONE: if (!out_valid_q || !out_stall) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
		if (key_wr)
			st_d = ST_KEXP;
	end

	// outputs of the sequencer
	always_comb begin
		q_pop = (st_q == ST_IDLE) && q_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_KEXP;
			rnd_q <= '0;
			key_hi_q <= '0; key_lo_q <= '0; iv_hi_q <= '0; iv_lo_q <= '0;
			fb_q <= '0;
			cmd_q <= '0;
			out_valid_q <= 1'b0;
			res_hi_q <= '0;
			res_lo_q <= '0;
			x_q[0] <= FK[0]; x_q[1] <= FK[1]; x_q[2] <= FK[2]; x_q[3] <= FK[3];
		end else begin
			st_q <= st_d;
			// raise on a new result, drop once the held word is taken
			if (load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			// store the written register; a fresh key half starts key expansion
			if (cfg_we) begin
				unique case (cfg_index)
					REG_KEY_HIGH: key_hi_q <= cfg_data;
					REG_KEY_LOW:  key_lo_q <= cfg_data;
					REG_IV_HIGH:  iv_hi_q <= cfg_data;
					REG_IV_LOW:   iv_lo_q <= cfg_data;
					default: ;
				endcase
			end
			if (key_wr) begin
				logic [63:0] kh, kl;
				kh = (cfg_index == REG_KEY_HIGH) ? cfg_data : key_hi_q;
				kl = (cfg_index == REG_KEY_LOW) ? cfg_data : key_lo_q;
				x_q[0] <= kh[63:32] ^ FK[0];
				x_q[1] <= kh[31:0] ^ FK[1];
				x_q[2] <= kl[63:32] ^ FK[2];
				x_q[3] <= kl[31:0] ^ FK[3];
				rnd_q <= '0;
			end else begin
				unique case (st_q)
					ST_KEXP: begin
						x_q[r5[1:0]] <= rk_new;
						rnd_q <= rnd_q + 6'd1;
					end
					ST_IDLE: if (q_valid) cmd_q <= q_cmd;
					ST_PREP: begin
						rnd_q <= '0;
						if (cmd_q.op == OP_OFB) begin
							logic [127:0] s;
							s = cmd_q.restart ? {iv_hi_q, iv_lo_q} : fb_q;
							x_q[0] <= s[127:96]; x_q[1] <= s[95:64];
							x_q[2] <= s[63:32]; x_q[3] <= s[31:0];
						end else begin
							x_q[0] <= cmd_q.data_high[63:32];
							x_q[1] <= cmd_q.data_high[31:0];
							x_q[2] <= cmd_q.data_low[63:32];
							x_q[3] <= cmd_q.data_low[31:0];
						end
					end
					ST_RUN: begin
						x_q[r5[1:0]] <= rk_new;
						rnd_q <= rnd_q + 6'd1;
					end
					ST_DONE: if (load_out) begin
						res_hi_q <= res_d[127:64];
						res_lo_q <= res_d[63:0];
						if (cmd_q.op == OP_OFB) fb_q <= fin;
					end
					default: ;
				endcase
			end
		end
	end

	assign out_valid = out_valid_q;
	assign result_high = res_hi_q;
	assign result_low = res_lo_q;

	`SM4_ASSERT_IMP(a_pop_idle, q_pop, st_q == ST_IDLE)
	`SM4_ASSERT_IMP(a_rnd_range, st_q == ST_RUN, rnd_q < 6'(RoundCount))
	`SM4_ASSERT_NXT(a_hold_out, out_valid_q && out_stall && !cfg_we, out_valid_q)
endmodule
`default_nettype wire

/* design/sm4_block_and_ofb_cipher_unit.sv */
// A block passes through the queue, the load step, the 32 rounds and the output register.
// Blocks are handled one at a time by the single shared round unit.
// A two-word queue lets input be taken while a block is in the rounds.
// Reset: registers clear and the round keys of the all-zero key are
// expanded; items wait in the queue until that ends.
// ----------------------------------------------------------------------------
// SM4 block and OFB cipher unit
// Top level: front queue and back end round engine.
// ----------------------------------------------------------------------------
`default_nettype none
module sm4_block_and_ofb_cipher_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  operation,
	input  wire logic        restart,
	input  wire logic [4:0]  byte_count,
	input  wire logic [63:0] data_high,
	input  wire logic [63:0] data_low,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      result_high,
	output logic [63:0]      result_low
);
	import sm4_pkg::*;

	cmd_t in_cmd, q_cmd;
	logic q_valid, q_pop;

	// bundle the input word
	always_comb begin
		in_cmd.op = op_t'(operation);
		in_cmd.restart = restart;
		in_cmd.byte_count = byte_count;
		in_cmd.data_high = data_high;
		in_cmd.data_low = data_low;
	end

	sm4_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_cmd(in_cmd), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd));

	sm4_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_high(result_high), .result_low(result_low));
endmodule
`default_nettype wire
